// ===== rtl/ptla_pkg.sv =====
`default_nettype none
package ptla_pkg;

  localparam int unsigned MaxPeersDef   = 16;
  localparam logic [31:0] TimeoutReset  = 32'd1000000;

  typedef enum logic [2:0] {
    REQ_ADD  = 3'd0,
    REQ_SEND = 3'd1,
    REQ_SET  = 3'd2,
    REQ_SEEN = 3'd3,
    REQ_SWEEP = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    ST_UNKNOWN    = 4'd0,
    ST_NOREPLY    = 4'd2,
    ST_INRANGE    = 4'd4,
    ST_CONNECTED  = 4'd5,
    ST_CONNECTING = 4'd6,
    ST_AVAILABLE  = 4'd7,
    ST_LOST       = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PASS,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [47:0] mac;
    logic [3:0]  status;
    logic [15:0] seq;
    logic [47:0] bcast;
    logic [47:0] ucast;
    logic [47:0] cstart;
  } entry_t;

  typedef struct packed {
    logic        full;
    logic [4:0]  cnt;
    logic [47:0] rmac;
    logic        creq;
    logic [3:0]  state;
    logic [15:0] seq;
    logic [3:0]  idx;
    logic        found;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/ptla_cell.sv =====
`default_nettype none
module ptla_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire ptla_pkg::entry_t entry_i,
  output ptla_pkg::entry_t     entry_o
);
  ptla_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

// ===== rtl/peer_table_with_link_aging_core.sv =====
`default_nettype none
// peer table with link aging
// requests come in on the s_axis channel: tuser holds the request kind, tdata the
// mac, the time stamp, the requested status and the unicast flag. results leave on
// the m_axis channel, tlast marks the final result of a request.
// entries sit in a ring of MAX_PEERS cells that rotates by one each cycle of the
// pass unless a stalled receiver holds a sweep; the controller works on the cell at
// the head, so a request visits every cell in the pass and then loads its closing
// result into the output register; the next request is accepted once that closing
// result has been loaded and the controller is back in idle.
// a sweep emits one result per stored peer and then a closing count; the ring
// only turns past a stored peer while the output register can take a result, so a
// stalled receiver holds the sweep in place and nothing is lost.
// a new request is taken only when the previous one has left the controller;
// the output register lets the next request start while a result waits.
// reset clears the peer count and global sequence, sets link_timeout to 1000000;
// table contents are not cleared, a peer slot is valid once added.
// link_timeout sits at apb address 0.
module peer_table_with_link_aging_core #(
  parameter int unsigned MAX_PEERS = ptla_pkg::MaxPeersDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // peer_mac, now_time, req_status, seen_unicast, zero pad
  input  wire logic [103:0]  s_axis_tdata_i,
  // req_type
  input  wire logic [2:0]    s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // found, entry_index, sequence_number, peer_state, connect_request,
  // request_mac, connected_count, table_full
  output logic [79:0]        m_axis_tdata_o,
  output logic               m_axis_tlast_o,
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic [2:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);
  localparam int unsigned KW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CW = $clog2(MAX_PEERS + 1);

  ptla_pkg::entry_t ring [MAX_PEERS];
  ptla_pkg::entry_t head_d;
  logic             shift;

  for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
    ptla_pkg::entry_t nxt;
    if (g == MAX_PEERS - 1) begin : g_tail
      assign nxt = head_d;
    end else begin : g_mid
      assign nxt = ring[g+1];
    end
    ptla_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .entry_i(nxt),
      .entry_o(ring[g])
    );
  end

  // config
  logic [31:0] timeout_q;
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == 1'b0) ? timeout_q : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ptla_pkg::TimeoutReset;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == 1'b0) begin
      timeout_q <= pwdata_i;
    end
  end

  ptla_pkg::fsm_e   state_q, state_d;
  logic [KW-1:0]    k_q, k_d;
  logic [CW-1:0]    count_q, count_d, conn_q, conn_d;
  logic [15:0]      gseq_q, gseq_d;
  logic [2:0]       req_q;
  logic [47:0]      mac_q, now_q;
  logic [3:0]       nst_q;
  logic             uni_q;
  logic             found_q, found_d;
  logic [3:0]       idx_q, idx_d, fst_q, fst_d;
  logic [15:0]      fseq_q, fseq_d;
  ptla_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic             out_free, take;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ptla_pkg::FSM_IDLE);
  assign take = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_q;
  assign m_axis_tlast_o = out_last_q;

  logic       slot_ok, hit, stale;
  logic [47:0] age_ref, age;
  ptla_pkg::entry_t head;
  assign head    = ring[0];
  assign slot_ok = CW'(k_q) < count_q;
  assign hit     = slot_ok && head.mac == mac_q && !found_q;
  always_comb begin
    case (head.status)
      ptla_pkg::ST_CONNECTED:  age_ref = head.ucast;
      ptla_pkg::ST_CONNECTING: age_ref = head.cstart;
      default:                 age_ref = head.bcast;
    endcase
  end
  assign age   = now_q - age_ref;
  assign stale = age > {16'd0, timeout_q};

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    count_d = count_q;
    conn_d = conn_q;
    gseq_d = gseq_q;
    found_d = found_q;
    idx_d = idx_q;
    fst_d = fst_q;
    fseq_d = fseq_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_last_d = out_last_q;
    head_d = head;
    shift = 1'b0;
    case (state_q)
      ptla_pkg::FSM_IDLE: begin
        if (take) begin
          k_d = '0;
          conn_d = '0;
          found_d = 1'b0;
          idx_d = '0;
          fst_d = '0;
          fseq_d = '0;
          if (s_axis_tuser_i <= ptla_pkg::REQ_SWEEP) begin
            state_d = ptla_pkg::FSM_PASS;
          end else begin
            state_d = ptla_pkg::FSM_DONE;
          end
        end
      end
      ptla_pkg::FSM_PASS: begin
        shift = 1'b1;
        case (req_q)
          ptla_pkg::REQ_ADD: begin
            if (hit) begin
              found_d = 1'b1;
              idx_d = 4'(k_q);
              fst_d = head.status;
            end
            if (CW'(k_q) == count_q && !found_q) begin
              head_d.mac = mac_q;
              head_d.status = ptla_pkg::ST_UNKNOWN;
              head_d.seq = '0;
              head_d.bcast = now_q;
              head_d.ucast = now_q;
            end
          end
          ptla_pkg::REQ_SEND: begin
            if (hit) begin
              found_d = 1'b1;
              idx_d = 4'(k_q);
              fst_d = head.status;
              fseq_d = head.seq;
              head_d.seq = head.seq + 16'd1;
            end
          end
          ptla_pkg::REQ_SET: begin
            if (hit) begin
              found_d = 1'b1;
              idx_d = 4'(k_q);
              fst_d = nst_q;
              head_d.status = nst_q;
            end
          end
          ptla_pkg::REQ_SEEN: begin
            if (hit) begin
              found_d = 1'b1;
              idx_d = 4'(k_q);
              fst_d = head.status;
              if (uni_q) head_d.ucast = now_q;
              else head_d.bcast = now_q;
            end
          end
          default: begin
            // sweep: one result per stored peer
            if (slot_ok) begin
              shift = out_free;
              out_d = '0;
              out_d.found = 1'b1;
              out_d.idx = 4'(k_q);
              if (head.status <= ptla_pkg::ST_INRANGE ||
                  head.status == ptla_pkg::ST_CONNECTED) begin
                if (stale) head_d.status = ptla_pkg::ST_LOST;
              end else if (head.status == ptla_pkg::ST_CONNECTING) begin
                if (stale) head_d.status = ptla_pkg::ST_NOREPLY;
              end else if (head.status == ptla_pkg::ST_AVAILABLE) begin
                head_d.cstart = now_q;
                head_d.seq = head.seq + 16'd1;
                head_d.status = ptla_pkg::ST_CONNECTING;
                out_d.seq = head.seq;
                out_d.creq = 1'b1;
                out_d.rmac = head.mac;
              end
              out_d.state = head_d.status;
              if (!out_free) begin
                out_d = out_q;
                head_d = head;
              end else begin
                out_valid_d = 1'b1;
                out_last_d = 1'b0;
                if (head_d.status == ptla_pkg::ST_CONNECTED) conn_d = conn_q + 1'b1;
              end
            end
          end
        endcase
        if (shift) begin
          k_d = k_q + 1'b1;
          if (k_q == KW'(MAX_PEERS - 1)) begin
            state_d = ptla_pkg::FSM_DONE;
          end
        end
      end
      ptla_pkg::FSM_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d = 1'b1;
          out_d = '0;
          state_d = ptla_pkg::FSM_IDLE;
          case (req_q)
            ptla_pkg::REQ_ADD: begin
              if (found_q) begin
                out_d.found = 1'b1;
                out_d.idx = idx_q;
                out_d.state = fst_q;
              end else if (count_q == CW'(MAX_PEERS)) begin
                out_d.full = 1'b1;
              end else begin
                out_d.idx = 4'(count_q);
                count_d = count_q + 1'b1;
              end
            end
            ptla_pkg::REQ_SEND: begin
              out_d.found = found_q;
              out_d.idx = idx_q;
              out_d.state = fst_q;
              if (found_q) begin
                out_d.seq = fseq_q;
              end else begin
                out_d.seq = gseq_q;
                gseq_d = gseq_q + 16'd1;
              end
            end
            ptla_pkg::REQ_SET, ptla_pkg::REQ_SEEN: begin
              out_d.found = found_q;
              out_d.idx = idx_q;
              out_d.state = fst_q;
            end
            ptla_pkg::REQ_SWEEP: begin
              out_d.cnt = 5'(conn_q);
            end
            default: ;
          endcase
        end
      end
      default: state_d = ptla_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptla_pkg::FSM_IDLE;
      k_q <= '0;
      count_q <= '0;
      conn_q <= '0;
      gseq_q <= '0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      count_q <= count_d;
      conn_q <= conn_d;
      gseq_q <= gseq_d;
      found_q <= found_d;
      out_valid_q <= out_valid_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    fst_q <= fst_d;
    fseq_q <= fseq_d;
    out_q <= out_d;
    if (take) begin
      req_q <= s_axis_tuser_i;
      mac_q <= s_axis_tdata_i[47:0];
      now_q <= s_axis_tdata_i[95:48];
      nst_q <= s_axis_tdata_i[99:96];
      uni_q <= s_axis_tdata_i[100];
    end
  end
endmodule
`default_nettype wire
